/* rtl/shrq_pkg.sv */
// ----------------------------------------------------------------------------
// shrq_pkg
// shared types and constants for the spatial hash radius query block
// ----------------------------------------------------------------------------
package shrq_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_DONE     = 3'd2;
    localparam logic [2:0] ST_CLIPPED  = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [1:0] REG_CELL = 2'd0;

    localparam int POS_W  = 24;
    localparam int RAD_W  = 23;
    localparam int ID_W   = 64;
    localparam int CNT_W  = 6;
    localparam int CELL_W = 26;

    typedef struct packed {
        logic [ID_W-1:0]  found_id;
        logic             match_valid;
        logic [CNT_W-1:0] match_count;
        logic [2:0]       status;
        logic             last;
    } shrq_result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_INS_HEAD,
        S_INS_WRITE,
        S_Q_CELL,
        S_Q_HEAD,
        S_Q_ENTRY,
        S_Q_TEST,
        S_Q_NEXT,
        S_EMIT
    } shrq_state_t;

endpackage

/* rtl/shrq_div.sv */
// ----------------------------------------------------------------------------
// shrq_div
// restoring floor divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module shrq_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [shrq_pkg::CELL_W-1:0] dividend,
    input  logic [shrq_pkg::RAD_W-1:0]    divisor,
    output logic                          done,
    output logic signed [shrq_pkg::CELL_W-1:0] quotient
);
    import shrq_pkg::*;

    localparam int QW = CELL_W - 1;

    logic [QW-1:0]      mag_reg, mag_next;
    logic [RAD_W:0]     rem_reg, rem_next;
    logic [QW-1:0]      q_reg, q_next;
    logic [RAD_W-1:0]   dv_reg, dv_next;
    logic               neg_reg, neg_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RAD_W:0]     trial;
    logic signed [CELL_W-1:0] qs;

    // negative operand: floor(a/b) = -((|a|-1)/b) - 1
    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[RAD_W-1:0], mag_reg[QW-1]};
        if (start)
        begin
            neg_next  = dividend[CELL_W-1];
            mag_next  = dividend[CELL_W-1] ? QW'(~dividend) : QW'(dividend);
            dv_next   = (divisor == '0) ? RAD_W'(1) : divisor;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 5'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, dv_reg})
            begin
                rem_next = trial - {1'b0, dv_reg};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dv_reg  <= dv_next;
        neg_reg <= neg_next;
    end

    assign qs       = $signed({1'b0, q_reg});
    assign quotient = neg_reg ? ~qs : qs;
    assign done     = done_reg;

endmodule

/* rtl/shrq_store.sv */
// ----------------------------------------------------------------------------
// shrq_store
// bucket head memory and entry pool memory, registered reads
// ----------------------------------------------------------------------------
module shrq_store #(
    parameter int BUCKETS      = 1024,
    parameter int POOL_ENTRIES = 4096
)
(
    input  logic                              clk,
    input  logic [$clog2(BUCKETS)-1:0]        head_addr,
    input  logic                              head_we,
    input  logic [$clog2(POOL_ENTRIES):0]     head_wdata,
    output logic [$clog2(POOL_ENTRIES):0]     head_rdata,
    input  logic [$clog2(POOL_ENTRIES)-1:0]   ent_addr,
    input  logic                              ent_we,
    input  logic [shrq_pkg::ID_W+2*shrq_pkg::POS_W+$clog2(POOL_ENTRIES):0] ent_wdata,
    output logic [shrq_pkg::ID_W+2*shrq_pkg::POS_W+$clog2(POOL_ENTRIES):0] ent_rdata
);
    import shrq_pkg::*;

    localparam int PW = $clog2(POOL_ENTRIES) + 1;
    localparam int EW = ID_W + 2*POS_W + PW;

    logic [PW-1:0] head_mem [BUCKETS];
    logic [EW-1:0] ent_mem  [POOL_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_addr] <= head_wdata;
        end
        head_rdata <= head_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_addr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[ent_addr];
    end

endmodule

/* rtl/spatial_hash_radius_query.sv */
// ----------------------------------------------------------------------------
// spatial_hash_radius_query
// spatial hash grid with insert, radius query and clear
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | cmd, ident, pos_x, pos_y, radius, result_limit
// m_axis  | out | found_id, match_valid, match_count, status, last
// apb     | in  | cell edge at 0x0
//
// insert: two divisions, a head read, then entry and head writes;
// clear: every bucket head written empty; query: four divisions, then per
// cell a head read, per chain entry a read and a test, per result a transfer
// after reset a clearing pass over all buckets runs before input is taken
// one command at a time; output stalls hold the walk in place
// ----------------------------------------------------------------------------
module spatial_hash_radius_query #(
    parameter int BUCKETS      = 1024,
    parameter int POOL_ENTRIES = 4096,
    parameter int MAX_SPAN     = 8,
    parameter int MAX_OUT      = 63
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] cmd, [65:2] ident, [89:66] pos_x, [113:90] pos_y,
    // [136:114] radius, [142:137] result_limit
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] found_id, [64] match_valid, [70:65] match_count
    output logic [71:0]  m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import shrq_pkg::*;

    localparam int BW  = $clog2(BUCKETS);
    localparam int PA  = $clog2(POOL_ENTRIES);
    localparam int PW  = PA + 1;
    localparam int EW  = ID_W + 2*POS_W + PW;
    localparam int SW  = $clog2(MAX_SPAN + 1);
    localparam logic [PW-1:0] EMPTY = PW'(POOL_ENTRIES);

    shrq_state_t state_reg, state_next;
    shrq_state_t ret_reg, ret_next;

    logic [RAD_W-1:0] cs_reg;
    logic [BW-1:0]    clr_reg, clr_next;
    logic [PW-1:0]    used_reg, used_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic signed [POS_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] lim_reg, lim_next, cnt_reg, cnt_next;
    logic [1:0]       dstep_reg, dstep_next;
    logic signed [CELL_W-1:0] minx_reg, minx_next, miny_reg, miny_next;
    logic signed [CELL_W-1:0] maxx_reg, maxx_next, maxy_reg, maxy_next;
    logic [SW-1:0]    nx_reg, nx_next, ny_reg, ny_next, ix_reg, ix_next, iy_reg, iy_next;
    logic             clip_reg, clip_next;
    logic [PW-1:0]    e_reg, e_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [ID_W-1:0]  eid_reg, eid_next;
    logic [PW-1:0]    elink_reg, elink_next;
    logic signed [POS_W:0] dx_reg, dx_next, dy_reg, dy_next;
    shrq_result_t     res_reg, res_next;
    logic             ov_reg, ov_next;

    logic             div_start;
    logic signed [CELL_W-1:0] div_a, div_q;
    logic             div_done;
    logic [BW-1:0]    head_addr;
    logic             head_we;
    logic [PW-1:0]    head_wdata, head_rdata;
    logic [PA-1:0]    ent_addr;
    logic             ent_we;
    logic [EW-1:0]    ent_wdata, ent_rdata;

    logic signed [CELL_W-1:0] cx, cy, spanx, spany;
    logic [31:0]      hx, hy;
    logic signed [2*POS_W+1:0] dx_sq, dy_sq;
    logic [2*POS_W+1:0] d2, r2;
    logic signed [POS_W-1:0] e_px, e_py;
    logic [2:0]       qstat;

    shrq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (cs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    shrq_store #(
        .BUCKETS      (BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_store (
        .clk        (clk),
        .head_addr  (head_addr),
        .head_we    (head_we),
        .head_wdata (head_wdata),
        .head_rdata (head_rdata),
        .ent_addr   (ent_addr),
        .ent_we     (ent_we),
        .ent_wdata  (ent_wdata),
        .ent_rdata  (ent_rdata)
    );

    assign pready = 1'b1;
    assign prdata = {9'd0, cs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= RAD_W'(256);
        end
        else if (psel && penable && pwrite && paddr == REG_CELL)
        begin
            cs_reg <= pwdata[RAD_W-1:0];
        end
    end

    assign cx   = minx_reg + CELL_W'(ix_reg);
    assign cy   = miny_reg + CELL_W'(iy_reg);
    assign hx   = 32'(cx) * 32'd1327;
    assign hy   = 32'(cy) * 32'd9001;
    assign spanx = maxx_reg - minx_reg + CELL_W'(1);
    assign spany = maxy_reg - miny_reg + CELL_W'(1);
    assign e_px = ent_rdata[ID_W+PW +: POS_W];
    assign e_py = ent_rdata[ID_W+PW+POS_W +: POS_W];
    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign d2   = $unsigned(dx_sq) + $unsigned(dy_sq);
    assign r2   = r_reg * r_reg;
    assign qstat = clip_reg ? ST_CLIPPED : ST_DONE;

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {1'b0, res_reg.match_count, res_reg.match_valid, res_reg.found_id};
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tlast  = res_reg.last;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        clr_next   = clr_reg;
        used_next  = used_reg;
        cmd_next   = cmd_reg;
        id_next    = id_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        r_next     = r_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        dstep_next = dstep_reg;
        minx_next  = minx_reg;
        miny_next  = miny_reg;
        maxx_next  = maxx_reg;
        maxy_next  = maxy_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        clip_next  = clip_reg;
        e_next     = e_reg;
        b_next     = b_reg;
        eid_next   = eid_reg;
        elink_next = elink_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !m_axis_tready;
        div_start  = 1'b0;
        div_a      = '0;
        head_addr  = b_reg;
        head_we    = 1'b0;
        head_wdata = EMPTY;
        ent_addr   = e_reg[PA-1:0];
        ent_we     = 1'b0;
        ent_wdata  = {py_reg, px_reg, head_rdata, id_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    cmd_next  = s_axis_tdata[1:0];
                    id_next   = s_axis_tdata[65:2];
                    px_next   = s_axis_tdata[89:66];
                    py_next   = s_axis_tdata[113:90];
                    r_next    = s_axis_tdata[136:114];
                    lim_next  = (s_axis_tdata[142:137] > CNT_W'(MAX_OUT))
                              ? CNT_W'(MAX_OUT) : s_axis_tdata[142:137];
                    cnt_next  = '0;
                    clip_next = 1'b0;
                    dstep_next = 2'd0;
                    unique case (s_axis_tdata[1:0])
                        CMD_INSERT:
                        begin
                            if (used_reg == EMPTY)
                            begin
                                res_next   = '{found_id: '0, match_valid: 1'b0,
                                              match_count: '0, status: ST_DROPPED, last: 1'b1};
                                state_next = S_EMIT;
                                ret_next   = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_DIV;
                                div_start  = 1'b1;
                                div_a      = CELL_W'($signed(s_axis_tdata[89:66]));
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = S_DIV;
                            div_start  = 1'b1;
                            div_a      = CELL_W'($signed(s_axis_tdata[89:66]))
                                       - CELL_W'(s_axis_tdata[136:114]);
                        end
                        CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                head_addr  = clr_reg;
                head_we    = 1'b1;
                clr_next   = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    used_next = '0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        res_next   = '{found_id: '0, match_valid: 1'b0,
                                      match_count: '0, status: ST_CLEARED, last: 1'b1};
                        state_next = S_EMIT;
                        ret_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    dstep_next = dstep_reg + 2'd1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (dstep_reg == 2'd0)
                        begin
                            minx_next = div_q;
                            div_start = 1'b1;
                            div_a     = CELL_W'(py_reg);
                        end
                        else
                        begin
                            miny_next  = div_q;
                            ix_next    = '0;
                            iy_next    = '0;
                            maxx_next  = minx_reg;
                            state_next = S_INS_HEAD;
                        end
                    end
                    else
                    begin
                        unique case (dstep_reg)
                            2'd0:
                            begin
                                minx_next = div_q;
                                div_a     = CELL_W'(px_reg) + CELL_W'(r_reg);
                            end
                            2'd1:
                            begin
                                maxx_next = div_q;
                                div_a     = CELL_W'(py_reg) - CELL_W'(r_reg);
                            end
                            2'd2:
                            begin
                                miny_next = div_q;
                                div_a     = CELL_W'(py_reg) + CELL_W'(r_reg);
                            end
                            default:
                            begin
                                maxy_next = div_q;
                            end
                        endcase
                        div_start = (dstep_reg != 2'd3);
                        if (dstep_reg == 2'd3)
                        begin
                            state_next = S_Q_CELL;
                        end
                    end
                end
            end
            S_INS_HEAD:
            begin
                head_addr  = BW'(hx ^ hy);
                b_next     = BW'(hx ^ hy);
                state_next = S_INS_WRITE;
            end
            S_INS_WRITE:
            begin
                ent_addr   = used_reg[PA-1:0];
                ent_we     = 1'b1;
                head_we    = 1'b1;
                head_wdata = used_reg;
                used_next  = used_reg + PW'(1);
                res_next   = '{found_id: '0, match_valid: 1'b0,
                              match_count: '0, status: ST_INSERTED, last: 1'b1};
                state_next = S_EMIT;
                ret_next   = S_IDLE;
            end
            S_Q_CELL:
            begin
                // first visit after divisions: clip spans
                if (dstep_reg == 2'd0)
                begin
                    dstep_next = 2'd1;
                    if (spanx > CELL_W'(MAX_SPAN))
                    begin
                        nx_next   = SW'(MAX_SPAN);
                        clip_next = 1'b1;
                    end
                    else
                    begin
                        nx_next = SW'(spanx);
                    end
                    if (spany > CELL_W'(MAX_SPAN))
                    begin
                        ny_next   = SW'(MAX_SPAN);
                        clip_next = 1'b1;
                    end
                    else
                    begin
                        ny_next = SW'(spany);
                    end
                    ix_next = '0;
                    iy_next = '0;
                end
                else if (cnt_reg >= lim_reg || ix_reg >= nx_reg)
                begin
                    // wait until the previous transfer has left
                    if (!ov_reg || m_axis_tready)
                    begin
                        res_next   = '{found_id: '0, match_valid: 1'b0,
                                      match_count: cnt_reg, status: qstat, last: 1'b1};
                        state_next = S_EMIT;
                        ret_next   = S_IDLE;
                    end
                end
                else if (iy_reg >= ny_reg)
                begin
                    ix_next = ix_reg + SW'(1);
                    iy_next = '0;
                end
                else
                begin
                    head_addr  = BW'(hx ^ hy);
                    iy_next    = iy_reg + SW'(1);
                    state_next = S_Q_HEAD;
                end
            end
            S_Q_HEAD:
            begin
                e_next     = head_rdata;
                state_next = S_Q_ENTRY;
            end
            S_Q_ENTRY:
            begin
                if (e_reg >= EMPTY || cnt_reg >= lim_reg)
                begin
                    state_next = S_Q_CELL;
                end
                else
                begin
                    ent_addr   = e_reg[PA-1:0];
                    state_next = S_Q_NEXT;
                end
            end
            S_Q_NEXT:
            begin
                dx_next    = (POS_W+1)'(e_px) - (POS_W+1)'(px_reg);
                dy_next    = (POS_W+1)'(e_py) - (POS_W+1)'(py_reg);
                eid_next   = ent_rdata[ID_W-1:0];
                elink_next = ent_rdata[ID_W +: PW];
                state_next = S_Q_TEST;
            end
            S_Q_TEST:
            begin
                if (d2 <= r2)
                begin
                    // wait until the previous transfer has left
                    if (!ov_reg || m_axis_tready)
                    begin
                        e_next     = elink_reg;
                        res_next   = '{found_id: eid_reg, match_valid: 1'b1,
                                      match_count: '0, status: qstat, last: 1'b0};
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = S_EMIT;
                        ret_next   = S_Q_ENTRY;
                    end
                end
                else
                begin
                    e_next     = elink_reg;
                    state_next = S_Q_ENTRY;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
            clr_reg   <= '0;
            used_reg  <= '0;
            cmd_reg   <= 2'd3;
            ov_reg    <= 1'b0;
            dstep_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            cmd_reg   <= cmd_next;
            ov_reg    <= ov_next;
            dstep_reg <= dstep_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        r_reg     <= r_next;
        lim_reg   <= lim_next;
        minx_reg  <= minx_next;
        miny_reg  <= miny_next;
        maxx_reg  <= maxx_next;
        maxy_reg  <= maxy_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        ix_reg    <= ix_next;
        iy_reg    <= iy_next;
        clip_reg  <= clip_next;
        e_reg     <= e_next;
        b_reg     <= b_next;
        eid_reg   <= eid_next;
        elink_reg <= elink_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        res_reg   <= res_next;
    end

endmodule

/* rtl/shrq_checker.sv */
// ----------------------------------------------------------------------------
// shrq_checker
// port-level checks for the spatial hash radius query block
// ----------------------------------------------------------------------------
module shrq_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import shrq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> !m_axis_tlast)
        else $error("match marked last");

    a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64]
            |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_CLIPPED))
        else $error("match with non-query status");

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");

endmodule

bind spatial_hash_radius_query shrq_checker u_shrq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the spatial hash radius query block: a queue of
// insert, query, clear and unused commands drives the input in random bursts,
// a grid model predicts every result transfer, and a monitor compares the
// output stream field by field while the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
module tb;
    import shrq_pkg::*;

    localparam int          NBUCKET    = 1024;
    localparam int          NPOOL      = 4096;
    localparam int          SPAN_MAX   = 8;
    localparam int          OUT_MAX    = 63;
    localparam int          CHAIN_END  = NPOOL;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]         cmd;
        logic [63:0]        id;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [22:0]        rad;
        logic [5:0]         lim;
    } cmd_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    spatial_hash_radius_query dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // grid model state
    int          grid_head [NBUCKET];
    logic [63:0] grid_id   [NPOOL];
    longint      grid_x    [NPOOL];
    longint      grid_y    [NPOOL];
    int          grid_link [NPOOL];
    int          grid_used;
    longint      grid_cell;

    cmd_item_t    cmd_pending [$];
    shrq_result_t result_due  [$];
    cmd_item_t    cur_cmd;
    int           errors;
    int           results_seen;
    longint       cycles;

    int  burst_left, gap_left;
    int  hold_cnt, stall_mode, stall_tick;
    bit  hold_done;

    always #5 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint floor_q(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic int bucket_of(input longint cx, input longint cy);
        longint hx, hy;
        hx = (cx * 1327) & 64'hFFFF_FFFF;
        hy = (cy * 9001) & 64'hFFFF_FFFF;
        return int'((hx ^ hy) & (NBUCKET - 1));
    endfunction

    task automatic due(input logic [63:0] id, input logic v, input logic [5:0] cnt,
                       input logic [2:0] st, input logic lst);
        shrq_result_t r;
        r.found_id    = id;
        r.match_valid = v;
        r.match_count = cnt;
        r.status      = st;
        r.last        = lst;
        result_due.push_back(r);
    endtask

    task automatic grid_apply(input cmd_item_t it);
        longint cs, x, y, r, r2, minx, maxx, miny, maxy, cx, cy, dx, dy;
        int b, e, lim, cnt;
        logic [2:0] st;
        cs = (grid_cell == 0) ? 1 : grid_cell;
        x = longint'(it.px);
        y = longint'(it.py);
        case (it.cmd)
            CMD_INSERT:
            begin
                if (grid_used >= NPOOL)
                    due(64'd0, 1'b0, 6'd0, ST_DROPPED, 1'b1);
                else
                begin
                    b = bucket_of(floor_q(x, cs), floor_q(y, cs));
                    grid_id[grid_used]   = it.id;
                    grid_x[grid_used]    = x;
                    grid_y[grid_used]    = y;
                    grid_link[grid_used] = grid_head[b];
                    grid_head[b]         = grid_used;
                    grid_used++;
                    due(64'd0, 1'b0, 6'd0, ST_INSERTED, 1'b1);
                end
            end
            CMD_QUERY:
            begin
                r    = longint'(it.rad);
                r2   = r * r;
                lim  = (it.lim > OUT_MAX) ? OUT_MAX : int'(it.lim);
                minx = floor_q(x - r, cs);
                maxx = floor_q(x + r, cs);
                miny = floor_q(y - r, cs);
                maxy = floor_q(y + r, cs);
                st   = ST_DONE;
                cnt  = 0;
                if (maxx - minx + 1 > SPAN_MAX)
                begin
                    maxx = minx + SPAN_MAX - 1;
                    st = ST_CLIPPED;
                end
                if (maxy - miny + 1 > SPAN_MAX)
                begin
                    maxy = miny + SPAN_MAX - 1;
                    st = ST_CLIPPED;
                end
                for (cx = minx; cx <= maxx && cnt < lim; cx++)
                    for (cy = miny; cy <= maxy && cnt < lim; cy++)
                    begin
                        e = grid_head[bucket_of(cx, cy)];
                        while (e < CHAIN_END && cnt < lim)
                        begin
                            dx = grid_x[e] - x;
                            dy = grid_y[e] - y;
                            if (dx * dx + dy * dy <= r2)
                            begin
                                due(grid_id[e], 1'b1, 6'd0, st, 1'b0);
                                cnt++;
                            end
                            e = grid_link[e];
                        end
                    end
                due(64'd0, 1'b0, 6'(cnt), st, 1'b1);
            end
            CMD_CLEAR:
            begin
                foreach (grid_head[i]) grid_head[i] = CHAIN_END;
                grid_used = 0;
                due(64'd0, 1'b0, 6'd0, ST_CLEARED, 1'b1);
            end
            default: ;
        endcase
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin : sender
        bit fire;
        if (rst_n)
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire) grid_apply(cur_cmd);
            if (!s_axis_tvalid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_pending.size() != 0)
                begin
                    cur_cmd = cmd_pending.pop_front();
                    s_axis_tdata <= {1'b0, cur_cmd.lim, cur_cmd.rad, cur_cmd.py,
                                     cur_cmd.px, cur_cmd.id, cur_cmd.cmd};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_tick++;
            if (stall_tick >= 64)
            begin
                stall_tick = 0;
                stall_mode = $urandom_range(0, 2);
            end
            if (!hold_done && results_seen >= 200)
            begin
                hold_done = 1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // result checking
    always @(posedge clk)
    begin : monitor
        shrq_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (result_due.size() == 0)
                report("result transfer with nothing expected");
            else
            begin
                exp_r = result_due.pop_front();
                if (m_axis_tdata[63:0] !== exp_r.found_id)
                    report($sformatf("found_id %h, want %h", m_axis_tdata[63:0],
                                     exp_r.found_id));
                if (m_axis_tdata[64] !== exp_r.match_valid)
                    report($sformatf("match_valid %b, want %b", m_axis_tdata[64],
                                     exp_r.match_valid));
                if (m_axis_tdata[70:65] !== exp_r.match_count)
                    report($sformatf("match_count %0d, want %0d", m_axis_tdata[70:65],
                                     exp_r.match_count));
                if (m_axis_tuser !== exp_r.status)
                    report($sformatf("status %0d, want %0d", m_axis_tuser, exp_r.status));
                if (m_axis_tlast !== exp_r.last)
                    report($sformatf("last %b, want %b", m_axis_tlast, exp_r.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", result_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] addr, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_CELL) grid_cell = longint'(val[22:0]);
    endtask

    // sampled between edges so that the driver's updates have settled
    task automatic drain();
        while (cmd_pending.size() != 0 || s_axis_tvalid || result_due.size() != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_cmd(input logic [1:0] c, input logic [63:0] id,
                            input longint x, input longint y,
                            input longint r, input int lim);
        cmd_item_t it;
        it.cmd = c;
        it.id  = id;
        it.px  = 24'(x);
        it.py  = 24'(y);
        it.rad = 23'(r);
        it.lim = 6'(lim);
        cmd_pending.push_back(it);
    endtask

    function automatic longint near_coord(input longint cs);
        longint w;
        w = cs * 3;
        if (w > 8388607) w = 8388607;
        if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom)));
        return longint'($urandom_range(0, 32'(2 * w))) - w;
    endfunction

    task automatic random_cmds(input int n);
        longint cs, r;
        int k;
        cs = (grid_cell == 0) ? 1 : grid_cell;
        repeat (n)
        begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) r = $urandom & 23'h7FFFFF;
            else r = $urandom_range(0, 32'((2 * cs > 8388607) ? 8388607 : 2 * cs));
            if (k < 55)
                push_cmd(CMD_INSERT, {$urandom, $urandom}, near_coord(cs), near_coord(cs),
                         0, 0);
            else if (k < 91)
                push_cmd(CMD_QUERY, {$urandom, $urandom}, near_coord(cs), near_coord(cs),
                         r, $urandom_range(0, 63));
            else if (k < 95)
                push_cmd(CMD_CLEAR, {$urandom, $urandom}, near_coord(cs), near_coord(cs),
                         r, $urandom_range(0, 63));
            else
                push_cmd(CMD_UNUSED, {$urandom, $urandom}, near_coord(cs), near_coord(cs),
                         r, $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        hold_cnt = 0;
        stall_mode = 0;
        stall_tick = 0;
        hold_done = 0;
        grid_used = 0;
        grid_cell = 256;
        foreach (grid_head[i]) grid_head[i] = CHAIN_END;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, floor of negatives, exact hit, limits, clipping
        push_cmd(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8388607, 8388607, 0, 0);
        push_cmd(CMD_INSERT, 64'd0, -8388608, -8388608, 0, 0);
        push_cmd(CMD_INSERT, 64'h1111, -1, -1, 0, 0);
        push_cmd(CMD_INSERT, 64'h2222, -256, 255, 0, 0);
        push_cmd(CMD_INSERT, 64'h3333, 0, 0, 0, 0);
        push_cmd(CMD_INSERT, 64'h4444, 100, -300, 0, 0);
        push_cmd(CMD_QUERY, 64'd0, 8388607, 8388607, 0, 63);
        push_cmd(CMD_QUERY, 64'd0, -8388608, -8388608, 0, 63);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 400, 63);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 400, 1);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 400, 0);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 8388607, 63);
        push_cmd(CMD_QUERY, 64'd0, -8388608, 8388607, 8388607, 63);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 1800, 63);
        push_cmd(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, -1, -1, 8388607, 63);
        push_cmd(CMD_CLEAR, 64'd0, 0, 0, 0, 0);
        push_cmd(CMD_QUERY, 64'd0, 0, 0, 8388607, 63);
        random_cmds(30);
        drain();

        // cell size sweep, extremes included
        reg_write(REG_CELL, 32'd1);
        random_cmds(60);
        drain();
        reg_write(REG_CELL, 32'h7F_FFFF);
        random_cmds(60);
        drain();
        reg_write(REG_CELL, 32'd0);
        random_cmds(50);
        drain();
        reg_write(REG_CELL, $urandom_range(2, 5000));
        random_cmds(60);
        drain();

        // back to the reset cell size with clears in between
        reg_write(REG_CELL, 32'd256);
        push_cmd(CMD_CLEAR, 64'd0, 0, 0, 0, 0);
        random_cmds(50);
        push_cmd(CMD_CLEAR, 64'd0, 0, 0, 0, 0);
        random_cmds(50);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
